@@ rtl/i2cms_pkg.sv @@
// Shared types and constants of the single-byte I2C master sequencer.
// No dependencies; every other file of the block except i2cms_if.sv imports this package.
package i2cms_pkg;

	localparam int unsigned Q_DEPTH = 2;
	localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd5;
	localparam logic [7:0] STATUS_MASK = 8'hF8;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RSTART      = 8'h10;
	localparam logic [7:0] ST_ADDR_ACK_W  = 8'h18;
	localparam logic [7:0] ST_ADDR_NACK_W = 8'h20;
	localparam logic [7:0] ST_DATA_ACK_W  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK_W = 8'h30;
	localparam logic [7:0] ST_ADDR_ACK_R  = 8'h40;
	localparam logic [7:0] ST_ADDR_NACK_R = 8'h48;
	localparam logic [7:0] ST_DATA_ACK_R  = 8'h50;
	localparam logic [7:0] ST_DATA_NACK_R = 8'h58;
	localparam logic [7:0] ST_BUS_ERR     = 8'h00;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WRITE,
		OP_READ,
		OP_EV_START,
		OP_EV_RSTART,
		OP_EV_ADDR_ACK_W,
		OP_EV_RETRY,
		OP_EV_DATA_ACK_W,
		OP_EV_DATA_NACK_W,
		OP_EV_ADDR_ACK_R,
		OP_EV_DATA_NACK_R,
		OP_EV_BUS_ERR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] addr;
		logic [7:0] dat;
	} entry_t;

	typedef struct packed {
		logic       cmd_start;
		logic       cmd_stop;
		logic       clear_start;
		logic       load_valid;
		logic [7:0] load_byte;
		logic       ack_enable;
		logic       bus_busy;
		logic       done_res;
		logic       success;
		logic [7:0] read_data;
		logic       rejected;
	} res_t;

endpackage

@@ rtl/i2cms_if.sv @@
// Request and result channel interfaces of the I2C master sequencer.
// Plain valid/ready channels; no package dependency.
interface i2cms_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [6:0] target_address;
	logic [7:0] write_data;
	logic [7:0] status_code;
	logic [7:0] rx_byte;

	modport source (output valid, req_type, target_address, write_data, status_code, rx_byte,
		input ready);
	modport sink (input valid, req_type, target_address, write_data, status_code, rx_byte,
		output ready);
endinterface

interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic       cmd_start;
	logic       cmd_stop;
	logic       clear_start;
	logic       load_valid;
	logic [7:0] load_byte;
	logic       ack_enable;
	logic       bus_busy;
	logic       done_res;
	logic       success;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, cmd_start, cmd_stop, clear_start, load_valid, load_byte,
		ack_enable, bus_busy, done_res, success, read_data, rejected, input ready);
	modport sink (input valid, cmd_start, cmd_stop, clear_start, load_valid, load_byte,
		ack_enable, bus_busy, done_res, success, read_data, rejected, output ready);
endinterface

@@ rtl/i2cms_front.sv @@
// Front end: classifies each incoming request or bus status event into an op.
// Depends on i2cms_pkg and i2cms_req_if.
module i2cms_front
	import i2cms_pkg::*;
(
	i2cms_req_if.sink  req,
	output logic       ent_valid,
	output entry_t     ent,
	input  logic       ent_ready
);

	logic [7:0] status_m;

	assign status_m  = req.status_code & STATUS_MASK;
	assign ent_valid = req.valid;
	assign req.ready = ent_ready;

	always_comb begin
		ent.addr = req.target_address;
		ent.dat  = (req.req_type == REQ_WRITE) ? req.write_data : req.rx_byte;
		ent.op   = OP_NOP;
		case (req.req_type)
			REQ_WRITE: ent.op = OP_WRITE;
			REQ_READ:  ent.op = OP_READ;
			REQ_EVENT: begin
				case (status_m)
					ST_START:       ent.op = OP_EV_START;
					ST_RSTART:      ent.op = OP_EV_RSTART;
					ST_ADDR_ACK_W:  ent.op = OP_EV_ADDR_ACK_W;
					ST_ADDR_NACK_W: ent.op = OP_EV_RETRY;
					ST_ADDR_NACK_R: ent.op = OP_EV_RETRY;
					ST_DATA_ACK_R:  ent.op = OP_EV_RETRY;
					ST_DATA_ACK_W:  ent.op = OP_EV_DATA_ACK_W;
					ST_DATA_NACK_W: ent.op = OP_EV_DATA_NACK_W;
					ST_ADDR_ACK_R:  ent.op = OP_EV_ADDR_ACK_R;
					ST_DATA_NACK_R: ent.op = OP_EV_DATA_NACK_R;
					ST_BUS_ERR:     ent.op = OP_EV_BUS_ERR;
					default:        ent.op = OP_NOP;
				endcase
			end
			default: ent.op = OP_NOP;
		endcase
	end

endmodule

@@ rtl/i2cms_queue.sv @@
// Short FIFO of classified ops between front end and sequencer back end.
// Depends on i2cms_pkg.
module i2cms_queue
	import i2cms_pkg::*;
#(
	parameter int unsigned DEPTH = Q_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  entry_t in_ent,
	output logic   out_valid,
	input  logic   out_ready,
	output entry_t out_ent
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != FULL);
	assign out_valid = (cnt_q != '0);
	assign out_ent   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				mem_q[wr_ptr_q] <= in_ent;
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/i2cms_back.sv @@
// Back end: transfer state, retry counting and command generation, with result register.
// Depends on i2cms_pkg and i2cms_res_if.
module i2cms_back
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       ent_valid,
	input  entry_t     ent,
	output logic       ent_ready,
	i2cms_res_if.source res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_ADDR  = 3'd2,
		PH_DATA  = 3'd3,
		PH_FINAL = 3'd4
	} phase_t;

	phase_t     phase_q, phase_n;
	logic       busy_q, busy_n;
	logic [7:0] cnt_q, cnt_n, cnt_inc;
	logic [7:0] addr_q, addr_n;
	logic [7:0] data_q, data_n;
	logic       acken_q, acken_n;
	logic [7:0] max_q;
	logic       res_valid_q;
	res_t       out_q, out_n;
	logic       fire;

	assign ent_ready = !res_valid_q || res.ready;
	assign fire      = ent_valid && ent_ready;
	assign cnt_inc   = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

	always_comb begin
		phase_n = phase_q;
		busy_n  = busy_q;
		cnt_n   = cnt_q;
		addr_n  = addr_q;
		data_n  = data_q;
		acken_n = acken_q;
		out_n   = '0;
		case (ent.op)
			OP_WRITE: begin
				cnt_n  = '0;
				data_n = ent.dat;
				addr_n = {ent.addr, 1'b0};
				phase_n = PH_START;
				out_n.cmd_start = 1'b1;
			end
			OP_READ: begin
				if (busy_q) begin
					out_n.rejected = 1'b1;
				end else begin
					cnt_n  = '0;
					data_n = '0;
					addr_n = {ent.addr, 1'b1};
					phase_n = PH_START;
					out_n.cmd_start = 1'b1;
				end
			end
			OP_EV_START: begin
				busy_n  = 1'b1;
				cnt_n   = cnt_inc;
				phase_n = PH_ADDR;
				out_n.load_valid  = 1'b1;
				out_n.load_byte   = addr_q;
				out_n.clear_start = 1'b1;
			end
			OP_EV_RSTART: begin
				cnt_n = cnt_inc;
				out_n.load_valid  = 1'b1;
				out_n.load_byte   = addr_q;
				out_n.clear_start = 1'b1;
			end
			OP_EV_ADDR_ACK_W: begin
				cnt_n   = cnt_inc;
				phase_n = PH_DATA;
				out_n.load_valid = 1'b1;
				out_n.load_byte  = data_q;
			end
			OP_EV_RETRY: begin
				if (cnt_q < max_q) begin
					cnt_n = cnt_inc;
					out_n.cmd_start = 1'b1;
				end else begin
					busy_n = 1'b0;
					out_n.cmd_stop = 1'b1;
					out_n.done_res = 1'b1;
				end
			end
			OP_EV_DATA_ACK_W: begin
				cnt_n   = cnt_inc;
				phase_n = PH_FINAL;
				busy_n  = 1'b0;
				out_n.cmd_stop = 1'b1;
				out_n.done_res = 1'b1;
			end
			OP_EV_DATA_NACK_W: begin
				cnt_n   = cnt_inc;
				phase_n = PH_DATA;
				out_n.load_valid = 1'b1;
				out_n.load_byte  = data_q;
			end
			OP_EV_ADDR_ACK_R: begin
				cnt_n   = cnt_inc;
				phase_n = PH_DATA;
				acken_n = 1'b0;
			end
			OP_EV_DATA_NACK_R: begin
				cnt_n   = cnt_inc;
				data_n  = ent.dat;
				phase_n = PH_FINAL;
				busy_n  = 1'b0;
				out_n.cmd_stop = 1'b1;
				out_n.done_res = 1'b1;
			end
			OP_EV_BUS_ERR: begin
				cnt_n = cnt_inc;
				out_n.cmd_start = 1'b1;
			end
			default: begin
			end
		endcase
		out_n.success   = out_n.done_res && (phase_n == PH_FINAL);
		out_n.read_data = (out_n.success && addr_n[0]) ? data_n : '0;
		out_n.ack_enable = acken_n;
		out_n.bus_busy   = busy_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			addr_q      <= '0;
			data_q      <= '0;
			acken_q     <= 1'b1;
			max_q       <= MAX_ATTEMPTS_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q     <= phase_n;
				busy_q      <= busy_n;
				cnt_q       <= cnt_n;
				addr_q      <= addr_n;
				data_q      <= data_n;
				acken_q     <= acken_n;
				out_q       <= out_n;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.cmd_start   = out_q.cmd_start;
	assign res.cmd_stop    = out_q.cmd_stop;
	assign res.clear_start = out_q.clear_start;
	assign res.load_valid  = out_q.load_valid;
	assign res.load_byte   = out_q.load_byte;
	assign res.ack_enable  = out_q.ack_enable;
	assign res.bus_busy    = out_q.bus_busy;
	assign res.done_res    = out_q.done_res;
	assign res.success     = out_q.success;
	assign res.read_data   = out_q.read_data;
	assign res.rejected    = out_q.rejected;

endmodule

@@ rtl/i2c_master_single_byte_sequencer.sv @@
// Single-byte I2C master sequencer. Each write request, read request or bus status event
// yields exactly one result with start/stop/load commands, ack enable, bus busy and,
// when the bus is freed, completion, success and read data. One item is accepted per
// clock while the op queue has room; each item passes through the op queue and then the
// result register, and the Q_DEPTH-entry op queue lets requests keep flowing for that
// many items while results are stalled. max_attempts is written through cfg_we.
module i2c_master_single_byte_sequencer
	import i2cms_pkg::*;
#(
	parameter int unsigned QDEPTH = Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	i2cms_req_if.sink   req,
	i2cms_res_if.source res
);

	logic   f_valid, f_ready;
	entry_t f_ent;
	logic   q_valid, q_ready;
	entry_t q_ent;

	i2cms_front u_front (
		.req       (req),
		.ent_valid (f_valid),
		.ent       (f_ent),
		.ent_ready (f_ready)
	);

	i2cms_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_ent    (f_ent),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_ent   (q_ent)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ent_valid (q_valid),
		.ent       (q_ent),
		.ent_ready (q_ready),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.rejected |-> res.bus_busy)
		else $error("rejected read without busy bus");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.bus_busy && !res.load_valid)
		else $error("completion with bus still busy");
	a_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.read_data != 8'd0) |-> res.success && res.done_res)
		else $error("read data outside successful completion");
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(q_valid))
		else $error("result without queued op");
`endif

endmodule

@@ verif/i2c_master_single_byte_sequencer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the single-byte I2C master sequencer.
// Uses i2cms_pkg, the i2cms_req_if/i2cms_res_if channels and the sequencer RTL;
// a directed request table is followed by random transfers checked by a predictor.
module i2c_master_single_byte_sequencer_tb;
	import i2cms_pkg::*;

	localparam logic [1:0] REQ_IDLE = 2'd3;
	localparam logic [7:0] ST_UNDECODED = 8'hF8;

	typedef enum logic [2:0] {PH_IDLE, PH_START, PH_ADDR, PH_DATA, PH_LAST} xfer_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] addr;
		logic [7:0] wdat;
		logic [7:0] stat;
		logic [7:0] rx;
	} bus_req_t;

	typedef struct {
		bus_req_t item;
		bit       typed;
		res_t     want;
	} stim_row_t;

	typedef struct {
		logic        busy;
		logic [7:0]  tries;
		xfer_phase_t phase;
		logic [7:0]  abyte;
		logic [7:0]  dbyte;
		logic        ack_en;
		logic [7:0]  limit;
	} seq_state_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	i2cms_req_if req_ch ();
	i2cms_res_if res_ch ();

	i2c_master_single_byte_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	seq_state_t seq_st;
	res_t       due_cmds [$];
	res_t       due;
	stim_row_t  req_table [$];
	int         n_errors = 0;
	bit         sender_steady = 0;
	bit         sink_steady = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		n_errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic void bump_tries();
		if (seq_st.tries != 8'hFF)
			seq_st.tries = seq_st.tries + 8'd1;
	endfunction

	task automatic predict_cmds(input bus_req_t q, output res_t r);
		logic [7:0] code;
		logic fin;
		r = '0;
		fin = 1'b0;
		code = q.stat & STATUS_MASK;
		case (q.kind)
			REQ_WRITE: begin
				seq_st.tries = 8'd0;
				seq_st.dbyte = q.wdat;
				seq_st.abyte = {q.addr, 1'b0};
				seq_st.phase = PH_START;
				r.cmd_start = 1'b1;
			end
			REQ_READ: begin
				if (seq_st.busy) begin
					r.rejected = 1'b1;
				end else begin
					seq_st.tries = 8'd0;
					seq_st.dbyte = 8'd0;
					seq_st.abyte = {q.addr, 1'b1};
					seq_st.phase = PH_START;
					r.cmd_start = 1'b1;
				end
			end
			REQ_EVENT: begin
				case (code)
					ST_START: begin
						seq_st.busy = 1'b1;
						bump_tries();
						seq_st.phase = PH_ADDR;
						r.load_valid = 1'b1;
						r.load_byte = seq_st.abyte;
						r.clear_start = 1'b1;
					end
					ST_RSTART: begin
						bump_tries();
						r.load_valid = 1'b1;
						r.load_byte = seq_st.abyte;
						r.clear_start = 1'b1;
					end
					ST_ADDR_ACK_W, ST_DATA_NACK_W: begin
						bump_tries();
						seq_st.phase = PH_DATA;
						r.load_valid = 1'b1;
						r.load_byte = seq_st.dbyte;
					end
					ST_ADDR_NACK_W, ST_ADDR_NACK_R, ST_DATA_ACK_R: begin
						if (seq_st.tries < seq_st.limit) begin
							bump_tries();
							r.cmd_start = 1'b1;
						end else begin
							r.cmd_stop = 1'b1;
							seq_st.busy = 1'b0;
							fin = 1'b1;
						end
					end
					ST_DATA_ACK_W: begin
						bump_tries();
						seq_st.phase = PH_LAST;
						r.cmd_stop = 1'b1;
						seq_st.busy = 1'b0;
						fin = 1'b1;
					end
					ST_ADDR_ACK_R: begin
						bump_tries();
						seq_st.phase = PH_DATA;
						seq_st.ack_en = 1'b0;
					end
					ST_DATA_NACK_R: begin
						bump_tries();
						seq_st.dbyte = q.rx;
						seq_st.phase = PH_LAST;
						r.cmd_stop = 1'b1;
						seq_st.busy = 1'b0;
						fin = 1'b1;
					end
					ST_BUS_ERR: begin
						bump_tries();
						r.cmd_start = 1'b1;
					end
					default: ;
				endcase
				r.done_res = fin;
				if (fin && seq_st.phase == PH_LAST) begin
					r.success = 1'b1;
					if (seq_st.abyte[0])
						r.read_data = seq_st.dbyte;
				end
			end
			default: ;
		endcase
		r.ack_enable = seq_st.ack_en;
		r.bus_busy = seq_st.busy;
	endtask

	function automatic res_t outcome(bit st, bit sp, bit clr, bit lv, logic [7:0] lb, bit ack,
			bit busy, bit done, bit succ, logic [7:0] rd, bit rej);
		res_t r;
		r = '{st, sp, clr, lv, lb, ack, busy, done, succ, rd, rej};
		return r;
	endfunction

	task automatic add_row(input logic [1:0] kind, input logic [6:0] addr, input logic [7:0] wd,
			input logic [7:0] stat, input logic [7:0] rx, input bit typed, input res_t want);
		stim_row_t row;
		row.item = '{kind, addr, wd, stat, rx};
		row.typed = typed;
		row.want = want;
		req_table.push_back(row);
	endtask

	function automatic bus_req_t ev(input logic [7:0] code);
		bus_req_t q;
		q.kind = REQ_EVENT;
		q.addr = 7'($urandom);
		q.wdat = 8'($urandom);
		q.rx = 8'($urandom);
		q.stat = {code[7:3], 3'($urandom)};
		return q;
	endfunction

	// Mostly follows the transfer the predictor is in; the rest is noise.
	function automatic bus_req_t pick_req();
		bus_req_t q;
		int roll;
		bit rd_dir;
		roll = $urandom_range(0, 99);
		rd_dir = seq_st.abyte[0];
		if (roll < 12) begin
			q = ev(8'($urandom));
			q.kind = 2'($urandom);
			q.stat = 8'($urandom);
		end else if (!seq_st.busy && seq_st.phase != PH_START) begin
			q = ev(ST_BUS_ERR);
			q.kind = ($urandom_range(0, 1) != 0) ? REQ_READ : REQ_WRITE;
		end else if (seq_st.phase == PH_START) begin
			q = ev(ST_START);
		end else if (seq_st.phase == PH_ADDR) begin
			if (roll < 60)
				q = ev(rd_dir ? ST_ADDR_ACK_R : ST_ADDR_ACK_W);
			else if (roll < 85)
				q = ev(rd_dir ? ST_ADDR_NACK_R : ST_ADDR_NACK_W);
			else
				q = ev(ST_RSTART);
		end else begin
			if (roll < 55)
				q = ev(rd_dir ? ST_DATA_NACK_R : ST_DATA_ACK_W);
			else if (roll < 90)
				q = ev(rd_dir ? ST_DATA_ACK_R : ST_DATA_NACK_W);
			else
				q = ev(ST_BUS_ERR);
		end
		return q;
	endfunction

	task automatic send_req(input bus_req_t q, input bit typed, input res_t want);
		res_t p;
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= q.kind;
		req_ch.target_address <= q.addr;
		req_ch.write_data <= q.wdat;
		req_ch.status_code <= q.stat;
		req_ch.rx_byte <= q.rx;
		do @(posedge clk); while (!req_ch.ready);
		predict_cmds(q, p);
		due_cmds.push_back(typed ? want : p);
	endtask

	task automatic set_limit(input logic [7:0] v);
		req_ch.valid <= 1'b0;
		while (due_cmds.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_st.limit = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_cmds.size() == 0) begin
				flag_error("result with no request outstanding");
			end else begin
				due = due_cmds.pop_front();
				cmp_field("cmd_start", res_ch.cmd_start, due.cmd_start);
				cmp_field("cmd_stop", res_ch.cmd_stop, due.cmd_stop);
				cmp_field("clear_start", res_ch.clear_start, due.clear_start);
				cmp_field("load_valid", res_ch.load_valid, due.load_valid);
				cmp_field("load_byte", res_ch.load_byte, due.load_byte);
				cmp_field("ack_enable", res_ch.ack_enable, due.ack_enable);
				cmp_field("bus_busy", res_ch.bus_busy, due.bus_busy);
				cmp_field("done_res", res_ch.done_res, due.done_res);
				cmp_field("success", res_ch.success, due.success);
				cmp_field("read_data", res_ch.read_data, due.read_data);
				cmp_field("rejected", res_ch.rejected, due.rejected);
			end
		end
	end

	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [7:0] lim_plan [0:7];
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'd0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_IDLE;
		req_ch.target_address <= 7'd0;
		req_ch.write_data <= 8'd0;
		req_ch.status_code <= 8'd0;
		req_ch.rx_byte <= 8'd0;
		seq_st.busy = 1'b0;
		seq_st.tries = 8'd0;
		seq_st.phase = PH_IDLE;
		seq_st.abyte = 8'd0;
		seq_st.dbyte = 8'd0;
		seq_st.ack_en = 1'b1;
		seq_st.limit = MAX_ATTEMPTS_RST;

		// idle items, a write transfer with retries, read rejected while busy,
		// write restarting a busy transfer, a read transfer, retry limit
		add_row(REQ_IDLE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, outcome(0,0,0,0,8'h00,1,0,0,0,8'h00,0));
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_UNDECODED | 8'h07, 8'h00, 1,
			outcome(0,0,0,0,8'h00,1,0,0,0,8'h00,0));
		add_row(REQ_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00, 1, outcome(1,0,0,0,8'h00,1,0,0,0,8'h00,0));
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_START | 8'h07, 8'h00, 1,
			outcome(0,0,1,1,8'hFE,1,1,0,0,8'h00,0));
		add_row(REQ_EVENT, 7'h2A, 8'h55, ST_ADDR_NACK_W | 8'h07, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_RSTART, 8'hFF, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_ADDR_ACK_W | 8'h05, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_DATA_NACK_W, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_DATA_ACK_W | 8'h03, 8'h00, 0, '0);
		add_row(REQ_READ, 7'h00, 8'hFF, 8'h00, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_START, 8'h00, 0, '0);
		add_row(REQ_READ, 7'h55, 8'hAA, 8'h00, 8'h00, 1, outcome(0,0,0,0,8'h00,1,1,0,0,8'h00,1));
		add_row(REQ_WRITE, 7'h00, 8'h00, 8'hFF, 8'hFF, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_DATA_ACK_W, 8'h00, 0, '0);
		add_row(REQ_READ, 7'h2A, 8'h00, 8'h00, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_START, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_ADDR_NACK_R, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_ADDR_ACK_R, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_DATA_ACK_R, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_DATA_NACK_R | 8'h07, 8'hA5, 1,
			outcome(0,1,0,0,8'h00,0,0,1,1,8'hA5,0));
		add_row(REQ_EVENT, 7'h7F, 8'hFF, ST_BUS_ERR, 8'hFF, 0, '0);
		add_row(REQ_WRITE, 7'h11, 8'h5A, 8'h00, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_START, 8'h00, 0, '0);
		for (k = 0; k < 4; k++)
			add_row(REQ_EVENT, 7'h00, 8'h00, ST_ADDR_NACK_W, 8'h00, 0, '0);
		add_row(REQ_EVENT, 7'h00, 8'h00, ST_ADDR_NACK_W, 8'h00, 1,
			outcome(0,1,0,0,8'h00,0,0,1,0,8'h00,0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < req_table.size(); k++)
			send_req(req_table[k].item, req_table[k].typed, req_table[k].want);

		lim_plan[0] = 8'd0;
		lim_plan[1] = 8'd255;
		lim_plan[2] = 8'd1;
		lim_plan[3] = 8'($urandom);
		lim_plan[4] = 8'd2;
		lim_plan[5] = 8'd5;
		lim_plan[6] = 8'd3;
		lim_plan[7] = 8'($urandom_range(0, 15));
		for (k = 0; k < 8; k++) begin
			set_limit(lim_plan[k]);
			sender_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			repeat (160) send_req(pick_req(), 0, '0);
		end

		// retry counter pinned at its top value, then an address NACK at the top limit
		set_limit(8'hFF);
		sender_steady = 1'b0;
		sink_steady = 1'b0;
		send_req('{REQ_WRITE, 7'($urandom), 8'($urandom), 8'h00, 8'h00}, 0, '0);
		send_req(ev(ST_START), 0, '0);
		repeat (300) send_req(ev(ST_BUS_ERR), 0, '0);
		send_req(ev(ST_ADDR_NACK_W), 0, '0);

		req_ch.valid <= 1'b0;
		while (due_cmds.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/i2cms_pkg.sv
rtl/i2cms_if.sv
rtl/i2cms_front.sv
rtl/i2cms_queue.sv
rtl/i2cms_back.sv
rtl/i2c_master_single_byte_sequencer.sv
verif/i2c_master_single_byte_sequencer_tb.sv
